/* design/npor_pkg.sv */
// Shared constants and types for the nibble-pair overwriting ring buffer.
// Used by npor_ctrl and nibble_pair_overwrite_ring_buffer; depends on nothing.
package npor_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int FILL_W     = 13;
    localparam int NIB_W      = 4;
    localparam int BYTE_W     = 8;

    localparam logic CMD_NIBBLE = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    // Memory requests and result flags for one accepted beat
    typedef struct packed {
        logic              wr_en;
        logic [PTR_W-1:0]  wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              rd_en;
        logic [PTR_W-1:0]  rd_addr;
        logic              pop_hit;
        logic              stored;
        logic              overwrote;
        logic [FILL_W-1:0] fill;
    } npor_op_t;

endpackage

/* design/npor_ctrl.sv */
// Pointer, full-mark and nibble-pairing state of the ring buffer.
// Issues the ring memory request for each accepted beat; uses npor_pkg.
module npor_ctrl
    import npor_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic             cmd,
    input  logic [NIB_W-1:0] nibble,
    output npor_op_t         op
);

    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_W  = (PTR_W + 1)'(RING_DEPTH);

    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic             full_reg, full_next;
    logic             half_due_reg, half_due_next;
    logic [NIB_W-1:0] held_nib_reg, held_nib_next;
    logic [PTR_W-1:0] rd_adv, wr_adv;
    logic [PTR_W:0]   level;

    assign rd_adv = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
    assign wr_adv = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;

    always_comb begin
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        full_next     = full_reg;
        half_due_next = half_due_reg;
        held_nib_next = held_nib_reg;
        op            = '0;
        op.wr_addr    = wr_ptr_reg;
        op.wr_data    = {held_nib_reg, nibble};
        op.rd_addr    = rd_ptr_reg;
        if (accept) begin
            if (cmd == CMD_POP) begin
                if (full_reg || (rd_ptr_reg != wr_ptr_reg)) begin
                    op.rd_en    = 1'b1;
                    op.pop_hit  = 1'b1;
                    rd_ptr_next = rd_adv;
                    full_next   = 1'b0;
                end
            end else if (!half_due_reg) begin
                held_nib_next = nibble;
                half_due_next = 1'b1;
            end else begin
                half_due_next = 1'b0;
                op.wr_en      = 1'b1;
                op.stored     = 1'b1;
                wr_ptr_next   = wr_adv;
                if (full_reg) begin
                    // drop the oldest byte
                    rd_ptr_next  = rd_adv;
                    op.overwrote = 1'b1;
                end else if (rd_ptr_reg == wr_adv) begin
                    full_next = 1'b1;
                end
            end
        end
        if (full_next) begin
            level = DEPTH_W;
        end else if (wr_ptr_next >= rd_ptr_next) begin
            level = {1'b0, wr_ptr_next} - {1'b0, rd_ptr_next};
        end else begin
            level = {1'b0, wr_ptr_next} + (DEPTH_W - {1'b0, rd_ptr_next});
        end
        op.fill = FILL_W'(level);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            full_reg     <= 1'b0;
            half_due_reg <= 1'b0;
            held_nib_reg <= '0;
        end else begin
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            full_reg     <= full_next;
            half_due_reg <= half_due_next;
            held_nib_reg <= held_nib_next;
        end
    end

endmodule

/* design/nibble_pair_overwrite_ring_buffer.sv */
// Top level of the nibble-pair overwriting ring buffer: ring memory, result pipeline.
// Depends on npor_pkg and npor_ctrl.
//
// Takes one beat per clock while s_tready is high, nibbles and pops mixed in any
// order, and returns exactly one result beat per input beat, in order. The
// synchronous read of the 4096-byte ring memory and the beat's flags are registered
// in stage st1 when a beat is accepted, and the output register takes them from st1
// when it is free. While an output beat waits, one more input beat is taken, and
// then s_tready drops. Pointer and pairing state update in the cycle a beat is
// accepted, so the next beat may follow immediately. The ring needs no clearing
// after reset; a pop only reads entries a push has written.
module nibble_pair_overwrite_ring_buffer
    import npor_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] nibble, [7:4] zero
    input  logic        s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data_byte, [8] byte_stored,
                                   // [9] overwrote_oldest, [22:10] fill_count, [23] zero
    output logic        m_tuser    // [0] byte_valid
);

    npor_op_t          op;
    logic              s_accept;
    logic              st1_move;

    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    logic              st1_valid_reg;
    logic              st1_hit_reg;
    logic              st1_stored_reg;
    logic              st1_ovw_reg;
    logic [FILL_W-1:0] st1_fill_reg;

    logic              out_valid_reg;
    logic              out_hit_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_stored_reg;
    logic              out_ovw_reg;
    logic [FILL_W-1:0] out_fill_reg;

    assign st1_move = st1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !st1_valid_reg || st1_move;
    assign s_accept = s_tvalid && s_tready;

    npor_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .cmd     (s_tuser),
        .nibble  (s_tdata[NIB_W-1:0]),
        .op      (op)
    );

    // Read data only changes on an accepted pop; a stalled pop keeps its byte.
    always_ff @(posedge aclk) begin
        if (op.wr_en) begin
            ring_mem[op.wr_addr] <= op.wr_data;
        end
        if (op.rd_en) begin
            rd_data_reg <= ring_mem[op.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                st1_valid_reg <= 1'b1;
            end else if (st1_move) begin
                st1_valid_reg <= 1'b0;
            end
            if (st1_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_hit_reg    <= op.pop_hit;
            st1_stored_reg <= op.stored;
            st1_ovw_reg    <= op.overwrote;
            st1_fill_reg   <= op.fill;
        end
        if (st1_move) begin
            out_hit_reg    <= st1_hit_reg;
            out_data_reg   <= st1_hit_reg ? rd_data_reg : '0;
            out_stored_reg <= st1_stored_reg;
            out_ovw_reg    <= st1_ovw_reg;
            out_fill_reg   <= st1_fill_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = {1'b0, out_fill_reg, out_ovw_reg, out_stored_reg, out_data_reg};

    a_empty_pop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[7:0] == 8'd0))
        else $error("empty pop or push result carries nonzero data byte");

    a_overwrite_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[9]) |-> (m_tdata[8] && (m_tdata[22:10] == FILL_W'(RING_DEPTH))))
        else $error("overwrite reported without a push into a full ring");

    a_pop_not_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> !m_tdata[8])
        else $error("result reports both a popped and a stored byte");

    a_read_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && st1_hit_reg && !st1_move) |=> $stable(rd_data_reg))
        else $error("ring read data changed under a stalled pop");

endmodule

/* tb/nibble_pair_overwrite_ring_buffer_checker.sv */
`timescale 1ns / 100ps
// Checker for the nibble-pair overwriting ring buffer: watches both stream channels,
// predicts every result beat from the accepted input beats and compares them in order.
// Depends on npor_pkg.
module nibble_pair_overwrite_ring_buffer_checker
    import npor_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] nibble, [7:4] zero
    input  logic        s_tuser,   // [0] cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [7:0] data_byte, [8] byte_stored,
                                   // [9] overwrote_oldest, [22:10] fill_count, [23] zero
    input  logic        m_tuser,   // [0] byte_valid
    output int          results_due,
    output int          fail_count
);

    typedef struct packed {
        logic              byte_valid;
        logic [BYTE_W-1:0] data_byte;
        logic              byte_stored;
        logic              overwrote_oldest;
        logic [FILL_W-1:0] fill_count;
    } ring_result_t;

    logic [BYTE_W-1:0] ring_copy [RING_DEPTH];
    int unsigned       oldest_idx;
    int unsigned       next_idx;
    bit                ring_is_full;
    bit                low_half_due;
    logic [NIB_W-1:0]  high_half;
    ring_result_t      awaited_results [$];
    int                failures;

    initial begin
        results_due = 0;
        fail_count  = 0;
        failures    = 0;
    end

    function automatic int unsigned step_ptr(input int unsigned p);
        return (p + 1) % RING_DEPTH;
    endfunction

    // Advance the ring copy by one input beat and return the result it should produce
    function automatic ring_result_t predict_ring_step(input logic cmd,
                                                       input logic [NIB_W-1:0] nib);
        ring_result_t r;
        int unsigned  level;
        r = '0;
        if (cmd == CMD_POP) begin
            if (ring_is_full || oldest_idx != next_idx) begin
                r.byte_valid = 1'b1;
                r.data_byte  = ring_copy[oldest_idx];
                oldest_idx   = step_ptr(oldest_idx);
                ring_is_full = 1'b0;
            end
        end else if (!low_half_due) begin
            high_half    = nib;
            low_half_due = 1'b1;
        end else begin
            low_half_due        = 1'b0;
            ring_copy[next_idx] = {high_half, nib};
            next_idx            = step_ptr(next_idx);
            r.byte_stored       = 1'b1;
            // a push into a full ring drops the oldest byte
            if (ring_is_full) begin
                oldest_idx         = step_ptr(oldest_idx);
                r.overwrote_oldest = 1'b1;
            end else if (oldest_idx == next_idx) begin
                ring_is_full = 1'b1;
            end
        end
        level = ring_is_full ? RING_DEPTH : (next_idx + RING_DEPTH - oldest_idx) % RING_DEPTH;
        r.fill_count = FILL_W'(level);
        return r;
    endfunction

    always @(posedge aclk) begin
        ring_result_t seen;
        ring_result_t want;
        if (!aresetn) begin
            oldest_idx   = 0;
            next_idx     = 0;
            ring_is_full = 1'b0;
            low_half_due = 1'b0;
            high_half    = '0;
            awaited_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                seen = {m_tuser, m_tdata[7:0], m_tdata[8], m_tdata[9], m_tdata[22:10]};
                if (awaited_results.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: result beat with none expected: valid=%0d byte=%02h",
                                 $time, seen.byte_valid, seen.data_byte);
                end else begin
                    want = awaited_results.pop_front();
                    if (seen.byte_valid !== want.byte_valid ||
                        seen.data_byte !== want.data_byte ||
                        seen.byte_stored !== want.byte_stored ||
                        seen.overwrote_oldest !== want.overwrote_oldest ||
                        seen.fill_count !== want.fill_count) begin
                        failures++;
                        if (failures <= 10)
                            $display({"%0t: result mismatch: expected valid=%0d byte=%02h ",
                                      "stored=%0d overwrote=%0d fill=%0d, got valid=%0d ",
                                      "byte=%02h stored=%0d overwrote=%0d fill=%0d"},
                                     $time, want.byte_valid, want.data_byte,
                                     want.byte_stored, want.overwrote_oldest,
                                     want.fill_count, seen.byte_valid, seen.data_byte,
                                     seen.byte_stored, seen.overwrote_oldest,
                                     seen.fill_count);
                    end
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(predict_ring_step(s_tuser, s_tdata[NIB_W-1:0]));
        end
        results_due <= awaited_results.size();
        fail_count  <= failures;
    end

endmodule

/* tb/nibble_pair_overwrite_ring_buffer_tb.sv */
`timescale 1ns / 100ps
// Testbench top for the nibble-pair overwriting ring buffer: clock, reset, stimulus
// and verdict. Depends on npor_pkg, the block and nibble_pair_overwrite_ring_buffer_checker.
module nibble_pair_overwrite_ring_buffer_tb;
    import npor_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = CMD_NIBBLE;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    logic        m_tuser;
    int          results_due;
    int          fail_count;
    bit          steady = 1'b0;
    int unsigned cycles = 0;

    always #5 aclk = ~aclk;

    nibble_pair_overwrite_ring_buffer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    nibble_pair_overwrite_ring_buffer_checker ring_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .results_due (results_due),
        .fail_count  (fail_count)
    );

    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 32);
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL nibble_pair_overwrite_ring_buffer");
            $finish;
        end
    end

    // Offer one beat after a random gap (none while steady) and hold it until accepted
    task automatic send_beat(input logic cmd, input logic [NIB_W-1:0] nib);
        while (!steady && $urandom_range(0, 99) < 32) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(8 - NIB_W){1'b0}}, nib};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_pair(input logic [BYTE_W-1:0] b);
        send_beat(CMD_NIBBLE, b[7:4]);
        send_beat(CMD_NIBBLE, b[3:0]);
    endtask

    task automatic send_mixed(input int count, input int pop_pct);
        repeat (count) begin
            if ($urandom_range(0, 99) < pop_pct)
                send_beat(CMD_POP, NIB_W'($urandom));
            else
                send_beat(CMD_NIBBLE, NIB_W'($urandom));
        end
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // empty pop, pop between the two halves of a pair, edge byte values
        send_beat(CMD_POP, 4'hF);
        send_beat(CMD_NIBBLE, 4'hF);
        send_beat(CMD_POP, 4'h0);
        send_beat(CMD_NIBBLE, 4'h0);
        send_pair(8'h0F);
        send_pair(8'hA5);
        send_pair(8'h5A);
        send_pair(8'hFF);
        send_pair(8'h00);
        repeat (7) send_beat(CMD_POP, NIB_W'($urandom));

        send_mixed(250, 30);
        steady <= 1'b1;
        send_mixed(200, 30);
        steady <= 1'b0;
        send_mixed(300, 30);
        wait_all_results();

        // pop repeatedly to drain the ring, then send mixed beats
        repeat (64) send_beat(CMD_POP, NIB_W'($urandom));
        send_mixed(20, 30);
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (fail_count == 0 && results_due == 0) begin
            $display("PASS nibble_pair_overwrite_ring_buffer");
        end else begin
            $display("FAIL nibble_pair_overwrite_ring_buffer");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/npor_pkg.sv
design/npor_ctrl.sv
design/nibble_pair_overwrite_ring_buffer.sv
tb/nibble_pair_overwrite_ring_buffer_checker.sv
tb/nibble_pair_overwrite_ring_buffer_tb.sv
